// ----- rtl/mlpbp_pkg.sv -----
package mlpbp_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int ACT_DEPTH    = 256;
    localparam int ACT_IDX_W    = 8;
    localparam int IN_COUNT     = 3;
    localparam int HID_COUNT    = 2;
    localparam int OUT_COUNT    = 3;
    localparam int HW_COUNT     = IN_COUNT * HID_COUNT;
    localparam int WEIGHT_COUNT = HW_COUNT + HID_COUNT * OUT_COUNT;
    localparam int WADDR_W      = $clog2(WEIGHT_COUNT);

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TRAIN = 2'd1;
    localparam logic [1:0] OP_INFER = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic CFG_LR  = 1'b0;
    localparam logic CFG_THR = 1'b1;

    typedef logic signed [13:0] act_t;
    typedef act_t act_table_t [ACT_DEPTH];

    // restoring shift-subtract quotient, used only while building the table
    function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // bipolar sigmoid tanh(a/2) sampled at bin centers, built at elaboration
    function automatic act_table_t build_act_table();
        act_table_t tbl;
        longint a;
        longint unsigned mag;
        longint unsigned y;
        longint unsigned e;
        longint unsigned term;
        longint unsigned num;
        longint unsigned den;
        longint unsigned v;
        for (int i = 0; i < ACT_DEPTH; i++) begin
            a = -64'sd32768 + (longint'(i) * 65536 + 32768) / ACT_DEPTH;
            mag = (a < 0) ? longint'(-a) : longint'(a);
            y = mag << 15;
            e = 64'd1 << 31;
            term = 64'd1 << 31;
            for (int n = 1; n <= 14; n++) begin
                term = udiv64((term * y) >> 31, longint'(n));
                if (n[0])
                    e = e - term;
                else
                    e = e + term;
            end
            for (int s = 0; s < 16 - FRAC_BITS; s++)
                e = (e * e) >> 31;
            num = ((64'd1 << 31) - e) << FRAC_BITS;
            den = (64'd1 << 31) + e;
            v = udiv64(num + (den >> 1), den);
            tbl[i] = (a < 0) ? -act_t'(v) : act_t'(v);
        end
        return tbl;
    endfunction

    localparam act_table_t ACT_TABLE = build_act_table();

    function automatic logic signed [15:0] sat16(logic signed [55:0] v);
        if (v > 56'sd32767)
            return 16'sh7FFF;
        else if (v < -56'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    // index = (a + 32768) * depth >> 16: top bits with the sign flipped
    function automatic act_t act_lookup(logic signed [15:0] a);
        logic [ACT_IDX_W-1:0] idx;
        idx = {~a[15], a[14:16-ACT_IDX_W]};
        return ACT_TABLE[idx];
    endfunction

    // (1 - y*y) / 2 in Q.12
    function automatic logic signed [15:0] deriv(act_t y);
        logic signed [27:0] sq;
        logic signed [15:0] t;
        sq = y * y;
        t = 16'sd4096 - 16'(sq >>> FRAC_BITS);
        return t >>> 1;
    endfunction

endpackage

// ----- rtl/mlpbp_ram.sv -----
module mlpbp_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 12,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mlp_backprop_train_step.sv -----
// 3-2-3 perceptron with tanh(a/2) activation from a 256-entry table and one
// backprop step per train word. The twelve Q3.12 weights live in one RAM
// (hidden weights at 0..5 as i*2+j, output weights at 6..11 as 6+j*3+k); one
// multiply-accumulate walks them, one RAM read per cycle. A load or no-op word
// answers in the cycle after it is taken; an inference or train word has its
// result once the result register is free, and a train word then goes on to
// error and weight write-back in a serial walk over the RAM port. One word is in
// work at a time; the next word is taken once the block is back in idle and the
// result register is free or being read. Weights must be loaded before use.
module mlp_backprop_train_step
    import mlpbp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [3:0]         weight_index,
    input  logic signed [15:0] weight_value,
    input  logic signed [15:0] in0,
    input  logic signed [15:0] in1,
    input  logic signed [15:0] in2,
    input  logic signed [13:0] target0,
    input  logic signed [13:0] target1,
    input  logic signed [13:0] target2,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [13:0] out0,
    output logic signed [13:0] out1,
    output logic signed [13:0] out2,
    output logic [15:0]        mse,
    output logic               converged,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HID   = 4'd1;
    localparam logic [3:0] S_HACT  = 4'd2;
    localparam logic [3:0] S_OUT   = 4'd3;
    localparam logic [3:0] S_OACT  = 4'd4;
    localparam logic [3:0] S_EO    = 4'd5;
    localparam logic [3:0] S_MSE   = 4'd6;
    localparam logic [3:0] S_EH    = 4'd7;
    localparam logic [3:0] S_HDER  = 4'd8;
    localparam logic [3:0] S_UPD_O = 4'd9;
    localparam logic [3:0] S_UPD_H = 4'd10;

    localparam logic [19:0] MSE_RECIP = 20'd349526;
    localparam int          MSE_SHIFT = 20;
    localparam int          UPD_SHIFT = 24;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  outer_reg, outer_next;
    logic [1:0]  inner_reg, inner_next;
    logic [12:0] lr_reg;
    logic [15:0] thr_reg;
    logic        out_valid_reg, out_valid_next;

    logic [1:0]         op_reg, op_next;
    logic signed [15:0] x_reg [IN_COUNT];
    logic signed [15:0] x_next [IN_COUNT];
    logic signed [13:0] t_reg [OUT_COUNT];
    logic signed [13:0] t_next [OUT_COUNT];
    act_t               hs_reg [HID_COUNT];
    act_t               hs_next [HID_COUNT];
    act_t               y_reg [OUT_COUNT];
    act_t               y_next [OUT_COUNT];
    logic signed [19:0] eo_reg [OUT_COUNT];
    logic signed [19:0] eo_next [OUT_COUNT];
    logic signed [33:0] le_reg [OUT_COUNT];
    logic signed [33:0] le_next [OUT_COUNT];
    logic signed [19:0] eh_reg [HID_COUNT];
    logic signed [19:0] eh_next [HID_COUNT];
    logic signed [33:0] lh_reg [HID_COUNT];
    logic signed [33:0] lh_next [HID_COUNT];
    logic signed [39:0] acc_reg, acc_next;
    logic [31:0]        sq_reg, sq_next;
    logic signed [15:0] d_reg, d_next;
    logic signed [15:0] accs_reg, accs_next;

    logic signed [13:0] res0_reg, res0_next;
    logic signed [13:0] res1_reg, res1_next;
    logic signed [13:0] res2_reg, res2_next;
    logic [15:0]        mse_reg, mse_next;
    logic               conv_reg, conv_next;

    logic               ram_we;
    logic [WADDR_W-1:0] ram_waddr;
    logic [15:0]        ram_wdata;
    logic [WADDR_W-1:0] ram_raddr;
    logic [15:0]        ram_rdata;
    logic signed [15:0] w_cur;

    logic               in_take;
    logic               out_free;
    logic signed [15:0] x_sel;
    act_t               hs_sel;
    logic signed [19:0] eo_sel;
    logic signed [19:0] mac_b;
    logic signed [35:0] mac_prod;
    logic signed [14:0] diff;
    logic signed [33:0] upd_a;
    logic signed [15:0] upd_b;
    logic signed [49:0] upd_prod;
    logic signed [55:0] upd_sum;
    logic [19:0]        mse_s;
    logic [39:0]        mse_prod;
    logic [19:0]        mse_q;
    logic [15:0]        mse_val;

    mlpbp_ram
    #(
        .WIDTH (16),
        .DEPTH (WEIGHT_COUNT)
    )
    u_weights
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign w_cur     = ram_rdata;
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign out0      = res0_reg;
    assign out1      = res1_reg;
    assign out2      = res2_reg;
    assign mse       = mse_reg;
    assign converged = conv_reg;

    // shared operand selects
    assign x_sel  = x_reg[(state_reg == S_UPD_H) ? outer_reg : inner_reg];
    assign hs_sel = hs_reg[(state_reg == S_OUT) ? inner_reg[0] : outer_reg[0]];
    assign eo_sel = eo_reg[(state_reg == S_EH) ? inner_reg : outer_reg];

    always_comb
    begin
        case (state_reg)
            S_HID:   mac_b = 20'(x_sel);
            S_OUT:   mac_b = 20'(hs_sel);
            S_EH:    mac_b = eo_sel;
            default: mac_b = '0;
        endcase
    end

    assign mac_prod = w_cur * mac_b;
    assign diff     = 15'(t_reg[outer_reg]) - 15'(y_reg[outer_reg]);

    assign upd_a    = (state_reg == S_UPD_O) ? le_reg[inner_reg] : lh_reg[inner_reg[0]];
    assign upd_b    = (state_reg == S_UPD_O) ? 16'(hs_sel) : x_sel;
    assign upd_prod = upd_a * upd_b;
    assign upd_sum  = 56'(w_cur) + 56'(upd_prod >>> UPD_SHIFT);

    // divide by OUT_COUNT << FRAC_BITS: shift, then reciprocal multiply by 3
    assign mse_s    = sq_reg[31:FRAC_BITS];
    assign mse_prod = mse_s * MSE_RECIP;
    assign mse_q    = mse_prod[39:MSE_SHIFT];
    assign mse_val  = (mse_q > 20'd65535) ? 16'hFFFF : mse_q[15:0];

    // read address follows the next step so the registered data lines up when that step is current
    always_comb
    begin
        case (state_next)
            S_HID:   ram_raddr = WADDR_W'({inner_next, 1'b0}) + WADDR_W'(outer_next);
            S_OUT:   ram_raddr = WADDR_W'(HW_COUNT) + WADDR_W'(inner_next) * WADDR_W'(OUT_COUNT)
                                 + WADDR_W'(outer_next);
            S_EH,
            S_UPD_O: ram_raddr = WADDR_W'(HW_COUNT) + WADDR_W'(outer_next) * WADDR_W'(OUT_COUNT)
                                 + WADDR_W'(inner_next);
            S_UPD_H: ram_raddr = WADDR_W'({outer_next, 1'b0}) + WADDR_W'(inner_next);
            default: ram_raddr = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        outer_next     = outer_reg;
        inner_next     = inner_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        t_next         = t_reg;
        hs_next        = hs_reg;
        y_next         = y_reg;
        eo_next        = eo_reg;
        le_next        = le_reg;
        eh_next        = eh_reg;
        lh_next        = lh_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        d_next         = d_reg;
        accs_next      = accs_reg;
        res0_next      = res0_reg;
        res1_next      = res1_reg;
        res2_next      = res2_reg;
        mse_next       = mse_reg;
        conv_next      = conv_reg;
        ram_we         = 1'b0;
        ram_waddr      = weight_index[WADDR_W-1:0];
        ram_wdata      = weight_value;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    op_next    = operation;
                    x_next[0]  = in0;
                    x_next[1]  = in1;
                    x_next[2]  = in2;
                    t_next[0]  = target0;
                    t_next[1]  = target1;
                    t_next[2]  = target2;
                    outer_next = '0;
                    inner_next = '0;
                    if (operation == OP_TRAIN || operation == OP_INFER)
                    begin
                        state_next = S_HID;
                    end
                    else
                    begin
                        // load and no-op answer at once with an all-zero word
                        if (operation == OP_LOAD && weight_index < 4'(WEIGHT_COUNT))
                            ram_we = 1'b1;
                        out_valid_next = 1'b1;
                        res0_next      = '0;
                        res1_next      = '0;
                        res2_next      = '0;
                        mse_next       = '0;
                        conv_next      = 1'b0;
                    end
                end
            end

            S_HID:
            begin
                acc_next = ((inner_reg == 2'd0) ? 40'sd0 : acc_reg) + 40'(mac_prod);
                if (inner_reg == 2'(IN_COUNT - 1))
                    state_next = S_HACT;
                else
                    inner_next = inner_reg + 2'd1;
            end

            S_HACT:
            begin
                hs_next[outer_reg[0]] = act_lookup(sat16(56'(acc_reg >>> FRAC_BITS)));
                inner_next = '0;
                if (outer_reg == 2'(HID_COUNT - 1))
                begin
                    state_next = S_OUT;
                    outer_next = '0;
                end
                else
                begin
                    state_next = S_HID;
                    outer_next = outer_reg + 2'd1;
                end
            end

            S_OUT:
            begin
                acc_next = ((inner_reg == 2'd0) ? 40'sd0 : acc_reg) + 40'(mac_prod);
                if (inner_reg == 2'(HID_COUNT - 1))
                    state_next = S_OACT;
                else
                    inner_next = inner_reg + 2'd1;
            end

            S_OACT:
            begin
                y_next[outer_reg] = act_lookup(sat16(56'(acc_reg >>> FRAC_BITS)));
                inner_next = '0;
                if (outer_reg == 2'(OUT_COUNT - 1))
                begin
                    state_next = S_EO;
                    outer_next = '0;
                    sq_next    = '0;
                end
                else
                begin
                    state_next = S_OUT;
                    outer_next = outer_reg + 2'd1;
                end
            end

            S_EO:
            begin
                case (inner_reg)
                    2'd0:
                    begin
                        d_next  = deriv(y_reg[outer_reg]);
                        sq_next = sq_reg + 32'(unsigned'(30'(diff * diff)));
                    end
                    2'd1:
                    begin
                        eo_next[outer_reg] = 20'(31'(diff * d_reg) >>> FRAC_BITS);
                    end
                    default:
                    begin
                        le_next[outer_reg] = 34'(signed'({1'b0, lr_reg}) * eo_reg[outer_reg]);
                    end
                endcase
                if (inner_reg == 2'd2)
                begin
                    inner_next = '0;
                    if (outer_reg == 2'(OUT_COUNT - 1))
                        state_next = S_MSE;
                    else
                        outer_next = outer_reg + 2'd1;
                end
                else
                begin
                    inner_next = inner_reg + 2'd1;
                end
            end

            S_MSE:
            begin
                // hold until the result register can take the word
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    res0_next      = y_reg[0];
                    res1_next      = y_reg[1];
                    res2_next      = y_reg[2];
                    mse_next       = mse_val;
                    conv_next      = (op_reg == OP_TRAIN) && (mse_val <= thr_reg);
                    outer_next     = '0;
                    inner_next     = '0;
                    state_next     = (op_reg == OP_TRAIN) ? S_EH : S_IDLE;
                end
            end

            S_EH:
            begin
                acc_next = ((inner_reg == 2'd0) ? 40'sd0 : acc_reg) + 40'(mac_prod);
                if (inner_reg == 2'(OUT_COUNT - 1))
                begin
                    state_next = S_HDER;
                    inner_next = '0;
                end
                else
                begin
                    inner_next = inner_reg + 2'd1;
                end
            end

            S_HDER:
            begin
                case (inner_reg)
                    2'd0:
                    begin
                        d_next    = deriv(hs_sel);
                        accs_next = sat16(56'(acc_reg >>> FRAC_BITS));
                    end
                    2'd1:
                    begin
                        eh_next[outer_reg[0]] = 20'(32'(accs_reg * d_reg) >>> FRAC_BITS);
                    end
                    default:
                    begin
                        lh_next[outer_reg[0]] =
                            34'(signed'({1'b0, lr_reg}) * eh_reg[outer_reg[0]]);
                    end
                endcase
                if (inner_reg == 2'd2)
                begin
                    inner_next = '0;
                    if (outer_reg == 2'(HID_COUNT - 1))
                    begin
                        state_next = S_UPD_O;
                        outer_next = '0;
                    end
                    else
                    begin
                        state_next = S_EH;
                        outer_next = outer_reg + 2'd1;
                    end
                end
                else
                begin
                    inner_next = inner_reg + 2'd1;
                end
            end

            S_UPD_O:
            begin
                ram_we    = 1'b1;
                ram_waddr = WADDR_W'(HW_COUNT) + WADDR_W'(outer_reg) * WADDR_W'(OUT_COUNT)
                            + WADDR_W'(inner_reg);
                ram_wdata = sat16(upd_sum);
                if (inner_reg == 2'(OUT_COUNT - 1))
                begin
                    inner_next = '0;
                    if (outer_reg == 2'(HID_COUNT - 1))
                    begin
                        state_next = S_UPD_H;
                        outer_next = '0;
                    end
                    else
                    begin
                        outer_next = outer_reg + 2'd1;
                    end
                end
                else
                begin
                    inner_next = inner_reg + 2'd1;
                end
            end

            S_UPD_H:
            begin
                ram_we    = 1'b1;
                ram_waddr = WADDR_W'({outer_reg, 1'b0}) + WADDR_W'(inner_reg);
                ram_wdata = sat16(upd_sum);
                if (inner_reg == 2'(HID_COUNT - 1))
                begin
                    inner_next = '0;
                    if (outer_reg == 2'(IN_COUNT - 1))
                    begin
                        state_next = S_IDLE;
                        outer_next = '0;
                    end
                    else
                    begin
                        outer_next = outer_reg + 2'd1;
                    end
                end
                else
                begin
                    inner_next = inner_reg + 2'd1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            outer_reg     <= '0;
            inner_reg     <= '0;
            out_valid_reg <= 1'b0;
            lr_reg        <= 13'd205;
            thr_reg       <= 16'd4;
        end
        else
        begin
            state_reg     <= state_next;
            outer_reg     <= outer_next;
            inner_reg     <= inner_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LR:  lr_reg  <= cfg_data[12:0];
                    CFG_THR: thr_reg <= cfg_data;
                    default: lr_reg  <= lr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        x_reg    <= x_next;
        t_reg    <= t_next;
        hs_reg   <= hs_next;
        y_reg    <= y_next;
        eo_reg   <= eo_next;
        le_reg   <= le_next;
        eh_reg   <= eh_next;
        lh_reg   <= lh_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        d_reg    <= d_next;
        accs_reg <= accs_next;
        res0_reg <= res0_next;
        res1_reg <= res1_next;
        res2_reg <= res2_next;
        mse_reg  <= mse_next;
        conv_reg <= conv_next;
    end

    a_take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> state_reg == S_IDLE)
        else $error("word taken while busy");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE || state_reg == S_UPD_O || state_reg == S_UPD_H))
        else $error("weight write outside load or update");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_IDLE || $past(state_reg) == S_MSE))
        else $error("result from unexpected step");

    a_converged_train: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && conv_reg) |-> op_reg == OP_TRAIN)
        else $error("converged flagged outside train");

endmodule

// ----- dv/mlp_backprop_train_step_test.sv -----
module mlp_backprop_train_step_test;
    import mlpbp_pkg::*;

    typedef struct {
        logic [1:0]         op;
        logic [3:0]         widx;
        logic signed [15:0] wval;
        logic signed [15:0] x0, x1, x2;
        logic signed [13:0] t0, t1, t2;
    } word_t;

    typedef struct {
        logic signed [13:0] y0, y1, y2;
        logic [15:0]        err;
        logic               conv;
    } net_out_t;

    typedef struct {
        word_t w;
        bit    zero_known;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         operation;
    logic [3:0]         weight_index;
    logic signed [15:0] weight_value;
    logic signed [15:0] in0, in1, in2;
    logic signed [13:0] target0, target1, target2;
    logic               out_valid;
    logic               out_stall;
    logic signed [13:0] out0, out1, out2;
    logic [15:0]        mse;
    logic               converged;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [15:0]        cfg_data;

    mlp_backprop_train_step u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .weight_index (weight_index),
        .weight_value (weight_value),
        .in0          (in0),
        .in1          (in1),
        .in2          (in2),
        .target0      (target0),
        .target1      (target1),
        .target2      (target2),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out0         (out0),
        .out1         (out1),
        .out2         (out2),
        .mse          (mse),
        .converged    (converged),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // predictor state
    longint   act_lut [256];
    longint   hid_w [6];
    longint   out_w [6];
    longint   lr_q;
    longint   thr_q;
    net_out_t pending_q [$];

    int  fail_count;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  quiet_burst;
    int  hold_req;
    int  n_train, n_infer, n_load, n_other, n_conv, n_checked;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(8 * 3_000_000);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void build_act_lut();
        longint a;
        longint unsigned y, e, term, num, den, v;
        for (int i = 0; i < 256; i++)
        begin
            a = -32768 + (longint'(i) * 65536 + 32768) / 256;
            y = longint'((a < 0) ? -a : a) << 15;
            e = 64'd1 << 31;
            term = 64'd1 << 31;
            for (int n = 1; n <= 14; n++)
            begin
                term = ((term * y) >> 31) / n;
                e = (n % 2 == 1) ? e - term : e + term;
            end
            repeat (4) e = (e * e) >> 31;
            num = ((64'd1 << 31) - e) << 12;
            den = (64'd1 << 31) + e;
            v = (num + den / 2) / den;
            act_lut[i] = (a < 0) ? -longint'(v) : longint'(v);
        end
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint squash(longint a);
        return act_lut[((a + 32768) * 256) >>> 16];
    endfunction

    function automatic longint slope(longint y);
        return (4096 - ((y * y) >>> 12)) >>> 1;
    endfunction

    // forward pass, plus one backprop update on a train word; a load word sets a weight
    function automatic net_out_t step_network(word_t w);
        net_out_t r;
        longint x [3];
        longint t [3];
        longint h [2];
        longint y [3];
        longint eo [3];
        longint eh [2];
        longint acc, sq, m;
        r = '{default: 0};
        if (w.op == OP_LOAD)
        begin
            if (w.widx < 6)
                hid_w[w.widx] = w.wval;
            else if (w.widx < 12)
                out_w[w.widx - 6] = w.wval;
            return r;
        end
        if (w.op == OP_NOP)
            return r;
        x = '{w.x0, w.x1, w.x2};
        t = '{w.t0, w.t1, w.t2};
        for (int j = 0; j < 2; j++)
        begin
            acc = 0;
            for (int i = 0; i < 3; i++)
                acc += hid_w[i * 2 + j] * x[i];
            h[j] = squash(clip16(acc >>> 12));
        end
        sq = 0;
        for (int k = 0; k < 3; k++)
        begin
            acc = 0;
            for (int j = 0; j < 2; j++)
                acc += out_w[j * 3 + k] * h[j];
            y[k] = squash(clip16(acc >>> 12));
            sq += (t[k] - y[k]) * (t[k] - y[k]);
        end
        m = sq / (3 * 4096);
        if (m > 65535)
            m = 65535;
        r.y0 = y[0];
        r.y1 = y[1];
        r.y2 = y[2];
        r.err = m;
        if (w.op != OP_TRAIN)
            return r;
        r.conv = (m <= thr_q);
        for (int k = 0; k < 3; k++)
            eo[k] = ((t[k] - y[k]) * slope(y[k])) >>> 12;
        for (int j = 0; j < 2; j++)
        begin
            acc = 0;
            for (int k = 0; k < 3; k++)
                acc += out_w[j * 3 + k] * eo[k];
            eh[j] = (clip16(acc >>> 12) * slope(h[j])) >>> 12;
        end
        for (int j = 0; j < 2; j++)
            for (int k = 0; k < 3; k++)
                out_w[j * 3 + k] = clip16(out_w[j * 3 + k] + ((lr_q * eo[k] * h[j]) >>> 24));
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 2; j++)
                hid_w[i * 2 + j] = clip16(hid_w[i * 2 + j] + ((lr_q * eh[j] * x[i]) >>> 24));
        return r;
    endfunction

    function automatic bit skip_cycle(int pct);
        return !quiet_burst && pct > 0 && $urandom_range(0, 99) < pct;
    endfunction

    task automatic send_word(word_t w, bit zero_known);
        net_out_t r;
        while (skip_cycle(tx_idle_pct))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= w.op;
        weight_index <= w.widx;
        weight_value <= w.wval;
        in0          <= w.x0;
        in1          <= w.x1;
        in2          <= w.x2;
        target0      <= w.t0;
        target1      <= w.t1;
        target2      <= w.t2;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = step_network(w);
        if (zero_known)
            r = '{default: 0};
        pending_q.push_back(r);
        case (w.op)
            OP_TRAIN: n_train++;
            OP_INFER: n_infer++;
            OP_LOAD:  n_load++;
            default:  n_other++;
        endcase
    endtask

    // drain, let the write-back of a train word finish, then write a register
    task automatic write_reg(logic idx, logic [15:0] val);
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_LR)
            lr_q = val & 16'h1FFF;
        else
            thr_q = val;
    endtask

    function automatic logic signed [15:0] pick16(bit tame);
        if (tame)
            return $urandom_range(0, 8192) - 4096;
        return $urandom;
    endfunction

    function automatic word_t rand_word(logic [1:0] op, bit tame);
        word_t w;
        w.op   = op;
        w.widx = (op == OP_LOAD) ? $urandom_range(0, 15) : $urandom;
        w.wval = pick16(tame);
        w.x0   = pick16(tame);
        w.x1   = pick16(tame);
        w.x2   = pick16(tame);
        if ($urandom_range(0, 9) == 0)
        begin
            w.t0 = $urandom;
            w.t1 = $urandom;
            w.t2 = $urandom;
        end
        else
        begin
            w.t0 = $urandom_range(0, 8192) - 4096;
            w.t1 = $urandom_range(0, 8192) - 4096;
            w.t2 = $urandom_range(0, 8192) - 4096;
        end
        return w;
    endfunction

    // result side: random stall, long hold on request
    initial
    begin
        net_out_t e;
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = pending_q.pop_front();
                    n_checked++;
                    if (converged)
                        n_conv++;
                    if (out0 !== e.y0)
                    begin
                        $error("out0 expected %0d got %0d", e.y0, out0);
                        fail_count++;
                    end
                    if (out1 !== e.y1)
                    begin
                        $error("out1 expected %0d got %0d", e.y1, out1);
                        fail_count++;
                    end
                    if (out2 !== e.y2)
                    begin
                        $error("out2 expected %0d got %0d", e.y2, out2);
                        fail_count++;
                    end
                    if (mse !== e.err)
                    begin
                        $error("mse expected %0d got %0d", e.err, mse);
                        fail_count++;
                    end
                    if (converged !== e.conv)
                    begin
                        $error("converged expected %0d got %0d", e.conv, converged);
                        fail_count++;
                    end
                end
            end
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= skip_cycle(rx_idle_pct);
        end
    end

    initial
    begin
        row_t  rows [$];
        word_t w;
        int    waited;
        logic [15:0] lr_set [4];
        logic [15:0] thr_set [4];

        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_NOP;
        weight_index = '0;
        weight_value = '0;
        in0 = '0;
        in1 = '0;
        in2 = '0;
        target0 = '0;
        target1 = '0;
        target2 = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LR;
        cfg_data = '0;
        fail_count = 0;
        hold_req = 0;
        quiet_burst = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        build_act_lut();
        hid_w = '{default: 0};
        out_w = '{default: 0};
        lr_q = 205;
        thr_q = 4;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // loads of every weight first, at the extremes and at mid values, so nothing reads an unset weight
        for (int i = 0; i < 12; i++)
        begin
            w = '{op: OP_LOAD, widx: i, wval: 0, x0: 0, x1: 0, x2: 0, t0: 0, t1: 0, t2: 0};
            case (i % 4)
                0: w.wval = 16'sh7FFF;
                1: w.wval = 16'sh8000;
                2: w.wval = 16'sd2048;
                default: w.wval = -16'sd1500;
            endcase
            rows.push_back('{w, 1'b1});
        end
        w = '{op: OP_LOAD, widx: 12, wval: 16'sh1234, x0: 0, x1: 0, x2: 0,
              t0: 0, t1: 0, t2: 0};
        rows.push_back('{w, 1'b1});
        w.widx = 15;
        w.wval = 16'shFFFF;
        rows.push_back('{w, 1'b1});
        w = '{op: OP_NOP, widx: 4'hF, wval: 16'sh7FFF, x0: 16'sh7FFF, x1: 16'sh8000,
              x2: 16'sh7FFF, t0: 14'sd4096, t1: -14'sd4096, t2: 0};
        rows.push_back('{w, 1'b1});
        w.op = OP_INFER;
        rows.push_back('{w, 1'b0});
        w.x0 = 16'sh8000;
        w.x1 = 16'sh8000;
        w.x2 = 16'sh8000;
        rows.push_back('{w, 1'b0});
        w.op = OP_TRAIN;
        rows.push_back('{w, 1'b0});
        w.x0 = 0;
        w.x1 = 0;
        w.x2 = 0;
        w.t0 = 0;
        w.t1 = 0;
        w.t2 = 0;
        rows.push_back('{w, 1'b0});
        // targets outside the activation range are taken as given
        w.x0 = 16'sd4096;
        w.t0 = 14'sh2000;
        w.t1 = 14'sh1FFF;
        w.t2 = -14'sd4096;
        rows.push_back('{w, 1'b0});
        w.op = OP_INFER;
        rows.push_back('{w, 1'b0});
        foreach (rows[i])
            send_word(rows[i].w, rows[i].zero_known);

        lr_set  = '{16'd4096, 16'd0, 16'hFFFF, 16'd205};
        thr_set = '{16'hFFFF, 16'd0, 16'd64, 16'h5A5A};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_LR, (ph == 3) ? 16'($urandom) : lr_set[ph]);
            write_reg(CFG_THR, (ph == 3) ? 16'($urandom) : thr_set[ph]);
            tx_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 49 : 0;
            rx_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 38 : 0;
            for (int n = 0; n < 400; n++)
            begin
                quiet_burst = (n % 80) >= 64;
                if (ph == 1 && n == 200)
                    hold_req = 400;
                if (n % 100 == 0)
                begin
                    // fresh small network, then train it on a few fixed patterns
                    for (int k = 0; k < 12; k++)
                    begin
                        w = rand_word(OP_LOAD, 1'b1);
                        w.widx = k;
                        send_word(w, 1'b0);
                    end
                end
                case ($urandom_range(0, 19))
                    0:       w = rand_word(OP_LOAD, $urandom_range(0, 1));
                    1:       w = rand_word(OP_NOP, 1'b0);
                    2, 3, 4: w = rand_word(OP_INFER, $urandom_range(0, 1));
                    5, 6:    w = rand_word(OP_TRAIN, 1'b0);
                    default:
                    begin
                        w = rand_word(OP_TRAIN, 1'b1);
                        w.x0 = (n % 4 < 2) ? 16'sd4096 : -16'sd4096;
                        w.x1 = (n % 2 == 0) ? 16'sd4096 : -16'sd4096;
                        w.x2 = 16'sd4096;
                        w.t0 = (n % 4 == 1 || n % 4 == 2) ? 14'sd3000 : -14'sd3000;
                        w.t1 = -w.t0;
                        w.t2 = 0;
                    end
                endcase
                send_word(w, 1'b0);
            end
        end
        in_valid <= 1'b0;

        waited = 0;
        while (pending_q.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (64) @(posedge clk);
        $display("words: %0d train, %0d infer, %0d load, %0d nop; results checked %0d",
                 n_train, n_infer, n_load, n_other, n_checked);
        $display("converged flags seen %0d over four rate/threshold settings", n_conv);
        if (fail_count == 0 && pending_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
